[design/nsd_pkg.sv]
// package for the nearest station distance ranking block
// holds sizes, key layout and the controller state type; no dependencies
package nsd_pkg;

  localparam int MAX_STATIONS = 64;
  localparam int MAX_HOUSES   = 64;

  localparam int COORD_W = 16;
  localparam int PRIO_W  = 16;
  localparam int DIST_W  = 35;
  localparam int SQ_W    = 32;
  localparam int NUM_W   = 7;

  localparam int ST_AW = (MAX_STATIONS > 1) ? $clog2(MAX_STATIONS) : 1;
  localparam int ST_CW = $clog2(MAX_STATIONS + 1);
  localparam int HS_AW = (MAX_HOUSES > 1) ? $clog2(MAX_HOUSES) : 1;
  localparam int HS_CW = $clog2(MAX_HOUSES + 1);

  localparam int STW = 2 * COORD_W;
  localparam int HSW = DIST_W + PRIO_W;
  localparam int KEY_W = DIST_W + PRIO_W + HS_AW;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIST,
    ST_HWR,
    ST_SORT,
    ST_EMIT
  } nsd_state_t;

endpackage

[design/nsd_ram.sv]
// generic single write port, single read port ram with registered read
// no dependencies
module nsd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[design/nearest_station_distance_ranking.sv]
// top level of the nearest station distance ranking block
// uses nsd_pkg and nsd_ram for station and house storage

// Station requests are stored on acceptance. A house request scans every stored
// station through the station memory, one station a cycle. The house request
// marked last then ranks the n stored houses by selection: each result costs
// one pass over the house memory plus the output state, which output stall can
// hold. No request is taken while a house is scanned or the list is sent.
// Stations stay stored until the list has been sent; memory contents need no
// clearing, only the counts reset.
module nearest_station_distance_ranking (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_func,
  input  logic signed [nsd_pkg::COORD_W-1:0] in_x_coord,
  input  logic signed [nsd_pkg::COORD_W-1:0] in_y_coord,
  input  logic [nsd_pkg::PRIO_W-1:0]   in_priority_req,
  input  logic                         in_last,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [nsd_pkg::NUM_W-1:0]    out_house_number,
  output logic                         out_end_of_list
);
  import nsd_pkg::*;

  nsd_state_t state_r, state_nxt;

  logic [ST_CW-1:0] station_count_r;
  logic [HS_CW-1:0] house_count_r;
  logic [ST_CW-1:0] ridx_r;
  logic [HS_CW-1:0] sidx_r;
  logic [HS_CW-1:0] rank_r;

  logic signed [COORD_W-1:0] hx_r, hy_r;
  logic [PRIO_W-1:0] hprio_r;
  logic              hlast_r;

  logic              dv1_r, dv2_r;
  logic [SQ_W-1:0]   sqx_r, sqy_r;
  logic [DIST_W-1:0] best_dist_r;

  logic              sv1_r;
  logic [HS_AW-1:0]  sidx_d_r;
  logic [KEY_W-1:0]  best_key_r, prev_key_r;
  logic              best_found_r;
  logic [NUM_W-1:0]  out_num_r;
  logic              out_end_r;

  logic accept, st_we, ra_full, hs_full, dist_done, sort_done, emit_take, last_rank;
  logic [STW-1:0] st_rdata;
  logic [HSW-1:0] hs_rdata;
  logic signed [COORD_W:0] dx, dy;
  logic signed [2*COORD_W+1:0] px, py;
  logic [SQ_W:0] dsum;
  logic [KEY_W-1:0] cand_key;
  logic cand_ok;

  assign accept    = in_valid && !in_stall;
  assign ra_full   = (station_count_r == ST_CW'(MAX_STATIONS));
  assign hs_full   = (house_count_r == HS_CW'(MAX_HOUSES));
  assign st_we     = accept && !in_func && !ra_full;
  assign dist_done = (ridx_r == station_count_r) && !dv1_r && !dv2_r;
  assign sort_done = (sidx_r == house_count_r) && !sv1_r;
  assign emit_take = (state_r == ST_EMIT) && !out_stall;
  assign last_rank = ((rank_r + HS_CW'(1)) == house_count_r);

  // station memory: x in the high half, y in the low half
  nsd_ram #(.WIDTH(STW), .DEPTH(MAX_STATIONS)) u_station_ram (
    .clk   (clk),
    .we    (st_we),
    .waddr (station_count_r[ST_AW-1:0]),
    .wdata ({in_x_coord, in_y_coord}),
    .raddr (ridx_r[ST_AW-1:0]),
    .rdata (st_rdata)
  );

  // house memory: distance above priority
  nsd_ram #(.WIDTH(HSW), .DEPTH(MAX_HOUSES)) u_house_ram (
    .clk   (clk),
    .we    (state_r == ST_HWR),
    .waddr (house_count_r[HS_AW-1:0]),
    .wdata ({best_dist_r, hprio_r}),
    .raddr (sidx_r[HS_AW-1:0]),
    .rdata (hs_rdata)
  );

  // squared distance terms of the station just read
  always_comb begin
    dx = (COORD_W+1)'(hx_r) - (COORD_W+1)'($signed(st_rdata[STW-1:COORD_W]));
    dy = (COORD_W+1)'(hy_r) - (COORD_W+1)'($signed(st_rdata[COORD_W-1:0]));
    px = dx * dx;
    py = dy * dy;
    dsum = {1'b0, sqx_r} + {1'b0, sqy_r};
  end

  // ranking key of the house just read; keys are unique through the index
  always_comb begin
    cand_key = {hs_rdata, sidx_d_r};
    cand_ok  = (rank_r == '0 || cand_key > prev_key_r) &&
               (!best_found_r || cand_key < best_key_r);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && in_func) begin
          if (!hs_full) state_nxt = ST_DIST;
          else if (in_last) state_nxt = (house_count_r == '0) ? ST_IDLE : ST_SORT;
        end
      end
      ST_DIST: if (dist_done) state_nxt = ST_HWR;
      ST_HWR:  state_nxt = hlast_r ? ST_SORT : ST_IDLE;
      ST_SORT: if (sort_done) state_nxt = ST_EMIT;
      ST_EMIT: if (!out_stall) state_nxt = last_rank ? ST_IDLE : ST_SORT;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_stall         = (state_r != ST_IDLE);
    out_valid        = (state_r == ST_EMIT);
    out_house_number = out_num_r;
    out_end_of_list  = out_end_r;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= ST_IDLE;
      station_count_r <= '0;
      house_count_r   <= '0;
      ridx_r          <= '0;
      sidx_r          <= '0;
      rank_r          <= '0;
      dv1_r           <= 1'b0;
      dv2_r           <= 1'b0;
      sv1_r           <= 1'b0;
      best_found_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (st_we) station_count_r <= station_count_r + ST_CW'(1);
      // station scan issue and pipeline valids
      dv1_r <= (state_r == ST_DIST) && (ridx_r != station_count_r);
      dv2_r <= dv1_r;
      if (accept) ridx_r <= '0;
      else if (state_r == ST_DIST && ridx_r != station_count_r) ridx_r <= ridx_r + ST_CW'(1);
      if (state_r == ST_HWR) house_count_r <= house_count_r + HS_CW'(1);
      // house scan issue
      sv1_r <= (state_r == ST_SORT) && (sidx_r != house_count_r);
      if (state_r == ST_SORT && sidx_r != house_count_r) sidx_r <= sidx_r + HS_CW'(1);
      if (sv1_r && cand_ok) best_found_r <= 1'b1;
      if (emit_take) begin
        sidx_r       <= '0;
        best_found_r <= 1'b0;
        if (last_rank) begin
          rank_r          <= '0;
          station_count_r <= '0;
          house_count_r   <= '0;
        end else begin
          rank_r <= rank_r + HS_CW'(1);
        end
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      hx_r        <= in_x_coord;
      hy_r        <= in_y_coord;
      hprio_r     <= in_priority_req;
      hlast_r     <= in_last;
      best_dist_r <= '1;
    end else if (dv2_r && ({{(DIST_W-SQ_W-1){1'b0}}, dsum} < best_dist_r)) begin
      best_dist_r <= {{(DIST_W-SQ_W-1){1'b0}}, dsum};
    end
    sqx_r    <= px[SQ_W-1:0];
    sqy_r    <= py[SQ_W-1:0];
    sidx_d_r <= sidx_r[HS_AW-1:0];
    if (sv1_r && cand_ok) best_key_r <= cand_key;
    if (state_r == ST_SORT && sort_done) begin
      out_num_r <= NUM_W'(best_key_r[HS_AW-1:0]) + NUM_W'(1);
      out_end_r <= last_rank;
    end
    if (emit_take) prev_key_r <= best_key_r;
  end

  // a ranked result always names a stored house
  a_out_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_house_number != '0 &&
                   NUM_W'(out_house_number) <= NUM_W'(house_count_r)))
    else $error("ranked house number outside stored houses");

  // the final result clears both counts
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && out_end_of_list) |=>
      (station_count_r == '0 && house_count_r == '0 && state_r == ST_IDLE))
    else $error("counts not cleared after final result");

  // station count never passes capacity
  a_st_cap: assert property (@(posedge clk) disable iff (!rst_n)
    station_count_r <= ST_CW'(MAX_STATIONS))
    else $error("station count over capacity");

  // a pass over the houses always finds a candidate
  a_sort_found: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SORT && sort_done) |-> best_found_r)
    else $error("selection pass found no house");

endmodule

[tb/tb_nearest_station_distance_ranking.sv]
// testbench for the nearest station distance ranking block
// depends on nsd_pkg and the nearest_station_distance_ranking top level
`timescale 1ns / 1ps

// ranking scoreboard: tracks stations and houses, predicts ranked house numbers
class rank_scoreboard;
  logic signed [nsd_pkg::COORD_W-1:0] stn_x[$];
  logic signed [nsd_pkg::COORD_W-1:0] stn_y[$];
  logic [nsd_pkg::DIST_W-1:0] hs_dist[$];
  logic [nsd_pkg::PRIO_W-1:0] hs_prio[$];
  logic [nsd_pkg::NUM_W-1:0] rank_q[$];
  logic end_q[$];
  int errors;
  int results;
  int lists;

  function automatic bit ranks_ahead(int a, int b);
    if (hs_dist[a] != hs_dist[b]) return hs_dist[a] < hs_dist[b];
    if (hs_prio[a] != hs_prio[b]) return hs_prio[a] < hs_prio[b];
    return a < b;
  endfunction

  // note one accepted request
  function automatic void note_request(logic func, logic signed [15:0] x,
                                       logic signed [15:0] y, logic [15:0] prio,
                                       logic lst);
    longint best, dx, dy, d;
    int order[$];
    int j;
    int cur;
    if (!func) begin
      if (stn_x.size() < nsd_pkg::MAX_STATIONS) begin
        stn_x = {stn_x, x};
        stn_y = {stn_y, y};
      end
      return;
    end
    if (hs_dist.size() < nsd_pkg::MAX_HOUSES) begin
      best = (64'd1 << nsd_pkg::DIST_W) - 1;
      foreach (stn_x[i]) begin
        dx = longint'(x) - longint'(stn_x[i]);
        dy = longint'(y) - longint'(stn_y[i]);
        d = dx * dx + dy * dy;
        if (d < best) best = d;
      end
      hs_dist = {hs_dist, best[nsd_pkg::DIST_W-1:0]};
      hs_prio = {hs_prio, prio};
    end
    if (!lst) return;
    // insertion sort by distance, priority, arrival
    for (int i = 0; i < hs_dist.size(); i++) begin
      cur = i;
      j = order.size();
      while (j > 0 && ranks_ahead(cur, order[j-1])) j--;
      order.insert(j, cur);
    end
    foreach (order[i]) begin
      rank_q = {rank_q, nsd_pkg::NUM_W'(order[i] + 1)};
      end_q = {end_q, (i == order.size() - 1)};
    end
    lists++;
    stn_x.delete();
    stn_y.delete();
    hs_dist.delete();
    hs_prio.delete();
  endfunction

  // compare one result with the oldest expectation
  function automatic void check_result(logic [6:0] num, logic eol);
    results++;
    if (rank_q.size() == 0) begin
      $error("unexpected result house_number=%0d", num);
      errors++;
      return;
    end
    if (num !== rank_q[0]) begin
      $error("house_number expected %0d actual %0d", rank_q[0], num);
      errors++;
    end
    if (eol !== end_q[0]) begin
      $error("end_of_list expected %0d actual %0d", end_q[0], eol);
      errors++;
    end
    void'(rank_q.pop_front());
    void'(end_q.pop_front());
  endfunction
endclass

module tb_nearest_station_distance_ranking;
  import nsd_pkg::*;

  localparam int WATCHDOG = 200000;

  logic clk;
  logic rst_n;
  logic in_valid, in_stall, in_func, in_last;
  logic signed [COORD_W-1:0] in_x_coord, in_y_coord;
  logic [PRIO_W-1:0] in_priority_req;
  logic out_valid, out_stall, out_end_of_list;
  logic [NUM_W-1:0] out_house_number;

  rank_scoreboard sb;
  int idle_cycles;
  int requests;
  bit hold_off;
  bit stim_done;

  nearest_station_distance_ranking u_top (
    .clk, .rst_n, .in_valid, .in_stall, .in_func, .in_x_coord, .in_y_coord,
    .in_priority_req, .in_last, .out_valid, .out_stall, .out_house_number,
    .out_end_of_list
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [15:0] rand_coord();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'h8000;
    if (r == 1) return 16'h7fff;
    if (r < 6) return 16'($urandom_range(0, 40) - 20);
    return 16'($urandom);
  endfunction

  // drive one request and wait for acceptance
  task automatic send(logic func, logic [15:0] x, logic [15:0] y,
                      logic [15:0] prio, logic lst);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_func <= func;
    in_x_coord <= x;
    in_y_coord <= y;
    in_priority_req <= prio;
    in_last <= lst;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(func, x, y, prio, lst);
    requests++;
    @(negedge clk);
  endtask

  // random set: stations then houses, last closes it
  task automatic random_set(int n_st, int n_hs, bit prio_ties);
    for (int i = 0; i < n_st; i++)
      send(1'b0, rand_coord(), rand_coord(), 16'($urandom), $urandom_range(0, 9) == 0);
    for (int i = 0; i < n_hs; i++)
      send(1'b1, rand_coord(), rand_coord(),
           prio_ties ? 16'($urandom_range(0, 2)) : 16'($urandom), i == n_hs - 1);
  endtask

  // receiver stall
  initial begin
    out_stall = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_off) begin
        out_stall <= 1'b1;
        repeat (600) @(negedge clk);
        hold_off = 1'b0;
      end
      if ($urandom_range(0, 60) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(10, 50)) @(negedge clk);
      end else begin
        out_stall <= ($urandom_range(0, 9) < 3) ? 1'b1 : 1'b0;
      end
    end
  end

  // result monitor and watchdog
  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) sb.check_result(out_house_number, out_end_of_list);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG) begin
        $display("watchdog: no handshake for %0d cycles", WATCHDOG);
        $display("** nearest_station_distance_ranking: FAILED **");
        $finish;
      end
    end
  end

  // stimulus
  initial begin
    sb = new();
    requests = 0;
    hold_off = 1'b0;
    stim_done = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_func = 1'b0;
    in_x_coord = '0;
    in_y_coord = '0;
    in_priority_req = '0;
    in_last = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: no stations, two houses
    send(1'b1, 16'h0000, 16'h0000, 16'h0005, 1'b0);
    send(1'b1, 16'h1234, 16'hffff, 16'h0001, 1'b1);
    // extremes, last on station ignored, station after houses, ties
    send(1'b0, 16'h8000, 16'h8000, 16'hffff, 1'b1);
    send(1'b0, 16'h7fff, 16'h7fff, 16'h0000, 1'b0);
    send(1'b1, 16'h7fff, 16'h8000, 16'hffff, 1'b0);
    send(1'b1, 16'h8000, 16'h7fff, 16'h0000, 1'b0);
    send(1'b1, 16'h0000, 16'h0000, 16'h0000, 1'b0);
    send(1'b0, 16'h0001, 16'h0001, 16'h0000, 1'b0);
    send(1'b1, 16'h0000, 16'h0000, 16'h0000, 1'b0);
    send(1'b1, 16'hffff, 16'hffff, 16'h0000, 1'b0);
    send(1'b1, 16'h0002, 16'h0002, 16'h0000, 1'b1);
    // single house at a station
    send(1'b0, 16'h0010, 16'hfff0, 16'h0000, 1'b0);
    send(1'b1, 16'h0010, 16'hfff0, 16'hffff, 1'b1);

    // station and house capacity overflow
    random_set(70, 68, 1'b1);

    // pressure: receiver holds off while a list is pending
    hold_off = 1'b1;
    random_set(3, 20, 1'b0);
    random_set(2, 10, 1'b1);

    // random sets, mostly small
    while (requests < 370) begin
      if ($urandom_range(0, 7) == 0) send(1'b1, rand_coord(), rand_coord(), 16'($urandom), 1'b1);
      else random_set($urandom_range(0, 8), $urandom_range(1, 10), $urandom_range(0, 1));
    end
    in_valid <= 1'b0;
    stim_done = 1'b1;

    while (sb.rank_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("covered %0d requests, %0d ranked lists, %0d results checked",
             requests, sb.lists, sb.results);
    $display("sets included empty station lists, both capacity overflows and long output stalls");
    if (sb.errors == 0 && sb.rank_q.size() == 0) begin
      $display("** nearest_station_distance_ranking: PASSED **");
    end else begin
      $display("** nearest_station_distance_ranking: FAILED **");
    end
    $finish;
  end
endmodule
